>>> hw/rtl/ahk_pkg.sv
// shared types, constants and helpers for the attitude and height estimator
`timescale 1ns / 1ps
package ahk_pkg;
    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] w_t;
    typedef logic signed [33:0] m_t;

    localparam int CORDIC_STEPS = 20;

    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [1:0] REG_PROCESS_VAR   = 2'd1;
    localparam logic [1:0] REG_MEAS_VAR      = 2'd2;

    localparam logic [16:0] SAMPLE_PERIOD_RST = 17'd655;
    localparam logic [30:0] VAR_RST           = 31'd65536;
    localparam q_t          Q_ONE             = 32'sd65536;

    localparam w_t HALF_TURN    = 64'sd11796480;
    localparam w_t QUARTER_TURN = 64'sd5898240;
    localparam w_t CORDIC_GAIN  = 64'sd652032874;
    localparam w_t NORM_LIMIT   = 64'sh0000_0100_0000_0000;

    typedef struct packed {
        logic start;
        logic vect;
        w_t   y;
        w_t   x;
        q_t   ang;
    } cor_req_t;

    function automatic q_t sat32(input w_t v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        else if (v < -64'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction

    function automatic w_t ext(input q_t v);
        return w_t'(v);
    endfunction

    // atan(2^-i) in degrees, q16.16
    function automatic logic [21:0] atan_tab(input logic [4:0] i);
        case (i)
            5'd0:    return 22'd2949120;
            5'd1:    return 22'd1740967;
            5'd2:    return 22'd919879;
            5'd3:    return 22'd466945;
            5'd4:    return 22'd234379;
            5'd5:    return 22'd117304;
            5'd6:    return 22'd58666;
            5'd7:    return 22'd29335;
            5'd8:    return 22'd14668;
            5'd9:    return 22'd7334;
            5'd10:   return 22'd3667;
            5'd11:   return 22'd1833;
            5'd12:   return 22'd917;
            5'd13:   return 22'd458;
            5'd14:   return 22'd229;
            5'd15:   return 22'd115;
            5'd16:   return 22'd57;
            5'd17:   return 22'd29;
            5'd18:   return 22'd14;
            5'd19:   return 22'd7;
            default: return 22'd0;
        endcase
    endfunction
endpackage

>>> hw/rtl/ahk_cordic.sv
// iterative cordic: atan2 in vectoring mode, sin and cos in rotation mode
`timescale 1ns / 1ps
module ahk_cordic (
    input  logic              aclk,
    input  logic              aresetn,
    input  ahk_pkg::cor_req_t req,
    output logic              done,
    output ahk_pkg::q_t       z_out,
    output ahk_pkg::q_t       c_out,
    output ahk_pkg::q_t       s_out
);
    import ahk_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NORM = 2'd1;
    localparam logic [1:0] ST_ITER = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] st_reg, st_next;
    w_t         x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic       vect_reg, vect_next, flip_reg, flip_next;
    logic [4:0] cnt_reg, cnt_next;
    w_t         ax, ay, mag, dx, dy, tab, xs, ys, ang;

    always_comb begin
        ax = (x_reg < 0) ? -x_reg : x_reg;
        ay = (y_reg < 0) ? -y_reg : y_reg;
        mag = (ax > ay) ? ax : ay;
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        tab = w_t'({42'd0, atan_tab(cnt_reg)});
        ang = ext(req.ang);
        st_next = st_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        vect_next = vect_reg;
        flip_next = flip_reg;
        cnt_next = cnt_reg;
        case (st_reg)
            ST_IDLE: begin
                if (req.start) begin
                    vect_next = req.vect;
                    flip_next = 1'b0;
                    cnt_next = 5'd0;
                    if (req.vect) begin
                        z_next = '0;
                        x_next = req.x;
                        y_next = req.y;
                        if (req.x == 0 && req.y == 0) begin
                            st_next = ST_DONE;
                        end else begin
                            if (req.x < 0) begin
                                z_next = (req.y >= 0) ? HALF_TURN : -HALF_TURN;
                                x_next = -req.x;
                                y_next = -req.y;
                            end
                            st_next = ST_NORM;
                        end
                    end else begin
                        x_next = CORDIC_GAIN;
                        y_next = '0;
                        z_next = ang;
                        if (ang > QUARTER_TURN) begin
                            z_next = ang - HALF_TURN;
                            flip_next = 1'b1;
                        end else if (ang < -QUARTER_TURN) begin
                            z_next = ang + HALF_TURN;
                            flip_next = 1'b1;
                        end
                        st_next = ST_ITER;
                    end
                end
            end
            ST_NORM: begin
                // scale up so the small steps keep their precision
                if (mag < NORM_LIMIT) begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end else begin
                    st_next = ST_ITER;
                end
            end
            ST_ITER: begin
                if (vect_reg ? (y_reg > 0) : (z_reg < 0)) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + tab;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - tab;
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) st_next = ST_DONE;
            end
            ST_DONE: st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        vect_reg <= vect_next;
        flip_reg <= flip_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        xs = flip_reg ? -x_reg : x_reg;
        ys = flip_reg ? -y_reg : y_reg;
    end

    assign done = (st_reg == ST_DONE);
    assign z_out = sat32(z_reg);
    assign c_out = xs[31:0];
    assign s_out = ys[31:0];
endmodule

>>> hw/rtl/ahk_div.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
module ahk_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  ahk_pkg::w_t num,
    input  logic [32:0] den,
    output logic        done,
    output ahk_pkg::w_t quo
);
    import ahk_pkg::*;

    logic        busy_reg, busy_next, done_reg, done_next, neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] mag_reg, mag_next;
    logic [32:0] rem_reg, rem_next, den_reg, den_next;
    logic [33:0] rem_sh, rem_sub;
    logic        ge;
    w_t          mag_s;

    always_comb begin
        rem_sh = {rem_reg, mag_reg[63]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        mag_next = mag_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (busy_reg) begin
            rem_next = ge ? rem_sub[32:0] : rem_sh[32:0];
            mag_next = {mag_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            neg_next = (num < 0);
            mag_next = (num < 0) ? 64'(-num) : 64'(num);
            rem_next = '0;
            den_next = den;
            cnt_next = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign mag_s = w_t'(mag_reg);
    assign quo = neg_reg ? -mag_s : mag_s;
    assign done = done_reg;
endmodule

>>> hw/rtl/ahk_sqrt.sv
// bit-pair integer square root of a 64-bit value, one step per cycle
`timescale 1ns / 1ps
module ahk_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] val,
    output logic        done,
    output logic [32:0] root
);
    import ahk_pkg::*;

    logic        busy_reg, busy_next, done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] v_reg, v_next, r_reg, r_next, bit_reg, bit_next, sum;

    always_comb begin
        sum = r_reg + bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        v_next = v_reg;
        r_next = r_reg;
        bit_next = bit_reg;
        if (busy_reg) begin
            if (v_reg >= sum) begin
                v_next = v_reg - sum;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            v_next = val;
            r_next = '0;
            bit_next = 64'h4000_0000_0000_0000;
            cnt_next = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        v_reg <= v_next;
        r_reg <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[32:0];
endmodule

>>> hw/rtl/imu_attitude_height_kalman_core.sv
// top level: sample sequencer, shared multiplier and state of the estimator
`timescale 1ns / 1ps
// Takes one IMU sample per beat (accel, gyro, field, baro height, all signed q16.16)
// and returns roll, pitch and yaw from three bias-tracking Kalman filters, the
// bias-corrected gyro integrals and the filtered and raw height. The first sample
// after reset only seeds the filters and gives no result. Each sample is worked
// through by one sequencer driving a registered 34x34 multiplier, a cordic unit,
// a one-bit-per-cycle divider and a square-root unit; s_tready is high only while
// the sequencer is idle. A seeding sample's time is set mostly by the three atan2
// and two sin/cos cordic passes and the normalizing shifts of the atan2 passes;
// every later sample's is set mostly by the ten divisions of the two covariance
// updates. A finished result waits in the output register, so the next sample
// can be taken before it is read.
module imu_attitude_height_kalman_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, field_x, field_y,
    // field_z, baro_height, 32 bits each
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // est_roll, est_pitch, est_yaw, integ_roll, integ_pitch, integ_yaw,
    // est_height, raw_height, 32 bits each
    output logic [255:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [30:0]  cfg_wdata
);
    import ahk_pkg::*;

    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_ROLL  = 6'd1;
    localparam logic [5:0] S_PITCH = 6'd2;
    localparam logic [5:0] S_SCR   = 6'd3;
    localparam logic [5:0] S_SCP   = 6'd4;
    localparam logic [5:0] S_T1    = 6'd5;
    localparam logic [5:0] S_T2    = 6'd6;
    localparam logic [5:0] S_T3    = 6'd7;
    localparam logic [5:0] S_T4    = 6'd8;
    localparam logic [5:0] S_T5    = 6'd9;
    localparam logic [5:0] S_T6    = 6'd10;
    localparam logic [5:0] S_T7    = 6'd11;
    localparam logic [5:0] S_T8    = 6'd12;
    localparam logic [5:0] S_YAW   = 6'd13;
    localparam logic [5:0] S_SEED  = 6'd14;
    localparam logic [5:0] S_C0    = 6'd15;
    localparam logic [5:0] S_C1    = 6'd16;
    localparam logic [5:0] S_C2    = 6'd17;
    localparam logic [5:0] S_C3    = 6'd18;
    localparam logic [5:0] S_C4    = 6'd19;
    localparam logic [5:0] S_C5    = 6'd20;
    localparam logic [5:0] S_C6    = 6'd21;
    localparam logic [5:0] S_K0    = 6'd22;
    localparam logic [5:0] S_K1    = 6'd23;
    localparam logic [5:0] S_MAA   = 6'd24;
    localparam logic [5:0] S_P0    = 6'd25;
    localparam logic [5:0] S_MAC   = 6'd26;
    localparam logic [5:0] S_P1    = 6'd27;
    localparam logic [5:0] S_MCC   = 6'd28;
    localparam logic [5:0] S_P3    = 6'd29;
    localparam logic [5:0] S_A0    = 6'd30;
    localparam logic [5:0] S_A1    = 6'd31;
    localparam logic [5:0] S_A2    = 6'd32;
    localparam logic [5:0] S_A3    = 6'd33;
    localparam logic [5:0] S_A4    = 6'd34;
    localparam logic [5:0] S_A5    = 6'd35;
    localparam logic [5:0] S_A6    = 6'd36;
    localparam logic [5:0] S_A7    = 6'd37;
    localparam logic [5:0] S_H0    = 6'd38;
    localparam logic [5:0] S_H1    = 6'd39;
    localparam logic [5:0] S_H2    = 6'd40;
    localparam logic [5:0] S_H3    = 6'd41;
    localparam logic [5:0] S_H4    = 6'd42;
    localparam logic [5:0] S_H5    = 6'd43;
    localparam logic [5:0] S_H6    = 6'd44;
    localparam logic [5:0] S_H7    = 6'd45;
    localparam logic [5:0] S_H8    = 6'd46;
    localparam logic [5:0] S_H9    = 6'd47;
    localparam logic [5:0] S_H10   = 6'd48;
    localparam logic [5:0] S_HU0   = 6'd49;
    localparam logic [5:0] S_HU1   = 6'd50;
    localparam logic [5:0] S_HU2   = 6'd51;
    localparam logic [5:0] S_HU3   = 6'd52;
    localparam logic [5:0] S_OUT   = 6'd53;

    logic [5:0]   st_reg, st_next;
    logic         launched_reg, launched_next, seeded_reg, seeded_next;
    logic         hsel_reg, hsel_next;
    logic [1:0]   ax_reg, ax_next;
    logic [16:0]  dt_reg, dt_next;
    logic [30:0]  qv_reg, qv_next, rv_reg, rv_next;
    logic         ovalid_reg, ovalid_next;
    logic [255:0] out_reg, out_next;

    q_t in_reg [10], in_next [10];
    q_t meas_reg [3], meas_next [3];
    q_t ang_reg [3], ang_next [3];
    q_t bias_reg [3], bias_next [3];
    q_t integ_reg [3], integ_next [3];
    q_t hs_reg [2], hs_next [2];
    q_t acov_reg [4], acov_next [4];
    q_t hcov_reg [4], hcov_next [4];

    q_t          cr_reg, cr_next, sr_reg, sr_next, cp_reg, cp_next, sp_reg, sp_next;
    q_t          pred_reg, pred_next, e_reg, e_next, k0_reg, k0_next, k1_reg, k1_next;
    q_t          ca_reg, ca_next, cb_reg, cb_next, cc_reg, cc_next, cd_reg, cd_next;
    q_t          accv_reg, accv_next;
    w_t          acc_reg, acc_next, tmp_reg, tmp_next, mx_reg, mx_next, my_reg, my_next;
    w_t          prod_reg, prod_next;
    logic [32:0] s_reg, s_next;
    logic [63:0] sq_reg, sq_next;

    m_t                ma, mb;
    logic signed [67:0] mprod;
    w_t                qm, f, dtw, qw, rw, rate, rmb, ssum, quo;
    q_t                p0, p1, p2, p3, cor_z, cor_c, cor_s;
    cor_req_t          cor_req;
    logic              cor_done, div_start, div_done, sq_start, sq_done;
    w_t                div_num;
    logic [32:0]       root;
    logic [3:0]        rate_idx;

    ahk_cordic u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (cor_req),
        .done   (cor_done),
        .z_out  (cor_z),
        .c_out  (cor_c),
        .s_out  (cor_s)
    );

    ahk_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (s_reg),
        .done   (div_done),
        .quo    (quo)
    );

    ahk_sqrt u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sq_start),
        .val    (sq_reg),
        .done   (sq_done),
        .root   (root)
    );

    always_comb begin
        qm = prod_reg >>> 16;
        dtw = w_t'({47'd0, dt_reg});
        qw = w_t'({33'd0, qv_reg});
        rw = w_t'({33'd0, rv_reg});
        f = hsel_reg ? dtw : -dtw;
        p0 = hsel_reg ? hcov_reg[0] : acov_reg[0];
        p1 = hsel_reg ? hcov_reg[1] : acov_reg[1];
        p2 = hsel_reg ? hcov_reg[2] : acov_reg[2];
        p3 = hsel_reg ? hcov_reg[3] : acov_reg[3];
        rate_idx = 4'd3 + {2'b00, ax_reg};
        rate = ext(in_reg[rate_idx]);
        rmb = rate - ext(bias_reg[ax_reg]);
        ssum = ext(ca_reg) + rw;
        mprod = ma * mb;
        prod_next = mprod[63:0];
    end

    always_comb begin
        st_next = st_reg;
        launched_next = launched_reg;
        seeded_next = seeded_reg;
        hsel_next = hsel_reg;
        ax_next = ax_reg;
        dt_next = dt_reg;
        qv_next = qv_reg;
        rv_next = rv_reg;
        ovalid_next = ovalid_reg && !m_tready;
        out_next = out_reg;
        in_next = in_reg;
        meas_next = meas_reg;
        ang_next = ang_reg;
        bias_next = bias_reg;
        integ_next = integ_reg;
        hs_next = hs_reg;
        acov_next = acov_reg;
        hcov_next = hcov_reg;
        cr_next = cr_reg;
        sr_next = sr_reg;
        cp_next = cp_reg;
        sp_next = sp_reg;
        pred_next = pred_reg;
        e_next = e_reg;
        k0_next = k0_reg;
        k1_next = k1_reg;
        ca_next = ca_reg;
        cb_next = cb_reg;
        cc_next = cc_reg;
        cd_next = cd_reg;
        accv_next = accv_reg;
        acc_next = acc_reg;
        tmp_next = tmp_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        s_next = s_reg;
        sq_next = sq_reg;
        ma = '0;
        mb = '0;
        cor_req = '0;
        div_start = 1'b0;
        div_num = prod_reg;
        sq_start = 1'b0;
        s_tready = (st_reg == S_IDLE);

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SAMPLE_PERIOD: dt_next = cfg_wdata[16:0];
                REG_PROCESS_VAR:   qv_next = cfg_wdata;
                REG_MEAS_VAR:      rv_next = cfg_wdata;
                default: ;
            endcase
        end

        case (st_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < 10; i++) in_next[i] = s_tdata[32*i +: 32];
                    hsel_next = 1'b0;
                    ax_next = 2'd0;
                    launched_next = 1'b0;
                    st_next = S_ROLL;
                end
            end
            S_ROLL, S_PITCH, S_YAW: begin
                cor_req.vect = 1'b1;
                cor_req.y = (st_reg == S_ROLL) ? ext(in_reg[1]) :
                            (st_reg == S_PITCH) ? ext(in_reg[0]) : my_reg;
                cor_req.x = (st_reg == S_YAW) ? mx_reg : ext(in_reg[2]);
                if (!launched_reg) begin
                    cor_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (cor_done) begin
                    launched_next = 1'b0;
                    if (st_reg == S_ROLL) begin
                        meas_next[0] = cor_z;
                        st_next = S_PITCH;
                    end else if (st_reg == S_PITCH) begin
                        meas_next[1] = cor_z;
                        st_next = S_SCR;
                    end else begin
                        meas_next[2] = cor_z;
                        st_next = seeded_reg ? S_C0 : S_SEED;
                    end
                end
            end
            S_SCR, S_SCP: begin
                cor_req.ang = (st_reg == S_SCR) ? meas_reg[0] : meas_reg[1];
                if (!launched_reg) begin
                    cor_req.start = 1'b1;
                    launched_next = 1'b1;
                end else if (cor_done) begin
                    launched_next = 1'b0;
                    if (st_reg == S_SCR) begin
                        cr_next = cor_c;
                        sr_next = cor_s;
                        st_next = S_SCP;
                    end else begin
                        cp_next = cor_c;
                        sp_next = cor_s;
                        st_next = S_T1;
                    end
                end
            end
            // tilt compensation of the field vector
            S_T1: begin
                ma = m_t'(in_reg[8]);
                mb = m_t'(cr_reg);
                st_next = S_T2;
            end
            S_T2: begin
                acc_next = prod_reg;
                ma = m_t'(in_reg[7]);
                mb = m_t'(sr_reg);
                st_next = S_T3;
            end
            S_T3: begin
                acc_next = acc_reg + prod_reg;
                st_next = S_T4;
            end
            S_T4: begin
                ma = m_t'(acc_reg >>> 30);
                mb = m_t'(sp_reg);
                st_next = S_T5;
            end
            S_T5: begin
                tmp_next = prod_reg;
                ma = m_t'(in_reg[6]);
                mb = m_t'(cp_reg);
                st_next = S_T6;
            end
            S_T6: begin
                mx_next = (tmp_reg + prod_reg) >>> 30;
                ma = m_t'(in_reg[7]);
                mb = m_t'(cr_reg);
                st_next = S_T7;
            end
            S_T7: begin
                tmp_next = prod_reg;
                ma = m_t'(in_reg[8]);
                mb = m_t'(sr_reg);
                st_next = S_T8;
            end
            S_T8: begin
                my_next = (tmp_reg - prod_reg) >>> 30;
                st_next = S_YAW;
            end
            S_SEED: begin
                for (int i = 0; i < 3; i++) begin
                    ang_next[i] = meas_reg[i];
                    integ_next[i] = meas_reg[i];
                    bias_next[i] = '0;
                end
                hs_next[0] = in_reg[9];
                hs_next[1] = '0;
                seeded_next = 1'b1;
                st_next = S_IDLE;
            end
            // covariance predict, shared by both filters
            S_C0: begin
                ma = m_t'(f);
                mb = m_t'(p2);
                st_next = S_C1;
            end
            S_C1: begin
                acc_next = ext(p0) + qw + qm;
                ma = m_t'(f);
                mb = m_t'(p1);
                st_next = S_C2;
            end
            S_C2: begin
                acc_next = acc_reg + qm;
                ma = m_t'(f);
                mb = m_t'(f);
                st_next = S_C3;
            end
            S_C3: begin
                tmp_next = qm;
                st_next = S_C4;
            end
            S_C4: begin
                ma = m_t'(tmp_reg);
                mb = m_t'(p3);
                st_next = S_C5;
            end
            S_C5: begin
                ca_next = sat32(acc_reg + qm);
                ma = m_t'(f);
                mb = m_t'(p3);
                st_next = S_C6;
            end
            S_C6: begin
                cb_next = sat32(ext(p1) + qm);
                cc_next = sat32(ext(p2) + qm);
                cd_next = sat32(ext(p3) + qw);
                s_next = (ssum < 1) ? 33'd1 : ssum[32:0];
                st_next = S_K0;
            end
            S_K0, S_K1, S_P0, S_P1, S_P3: begin
                if (st_reg == S_K0) div_num = ext(ca_reg) <<< 16;
                else if (st_reg == S_K1) div_num = ext(cc_reg) <<< 16;
                if (!launched_reg) begin
                    div_start = 1'b1;
                    launched_next = 1'b1;
                end else if (div_done) begin
                    launched_next = 1'b0;
                    case (st_reg)
                        S_K0: begin
                            k0_next = sat32(quo);
                            st_next = S_K1;
                        end
                        S_K1: begin
                            k1_next = sat32(quo);
                            st_next = S_MAA;
                        end
                        S_P0: begin
                            if (hsel_reg) hcov_next[0] = sat32(ext(ca_reg) - quo);
                            else acov_next[0] = sat32(ext(ca_reg) - quo);
                            st_next = S_MAC;
                        end
                        S_P1: begin
                            if (hsel_reg) begin
                                hcov_next[1] = sat32(ext(cb_reg) - quo);
                                hcov_next[2] = sat32(ext(cc_reg) - quo);
                            end else begin
                                acov_next[1] = sat32(ext(cb_reg) - quo);
                                acov_next[2] = sat32(ext(cc_reg) - quo);
                            end
                            st_next = S_MCC;
                        end
                        default: begin
                            if (hsel_reg) hcov_next[3] = sat32(ext(cd_reg) - quo);
                            else acov_next[3] = sat32(ext(cd_reg) - quo);
                            st_next = hsel_reg ? S_HU0 : S_A0;
                        end
                    endcase
                end
            end
            S_MAA: begin
                ma = m_t'(ca_reg);
                mb = m_t'(ca_reg);
                st_next = S_P0;
            end
            S_MAC: begin
                ma = m_t'(ca_reg);
                mb = m_t'(cc_reg);
                st_next = S_P1;
            end
            S_MCC: begin
                ma = m_t'(cc_reg);
                mb = m_t'(cc_reg);
                st_next = S_P3;
            end
            // one angle axis per pass
            S_A0: begin
                ma = m_t'({1'b0, dt_reg});
                mb = m_t'(rmb);
                st_next = S_A1;
            end
            S_A1: begin
                pred_next = sat32(ext(ang_reg[ax_reg]) + qm);
                st_next = S_A2;
            end
            S_A2: begin
                e_next = sat32(ext(meas_reg[ax_reg]) - ext(pred_reg));
                st_next = S_A3;
            end
            S_A3: begin
                ma = m_t'(k0_reg);
                mb = m_t'(e_reg);
                st_next = S_A4;
            end
            S_A4: begin
                ang_next[ax_reg] = sat32(ext(pred_reg) + qm);
                ma = m_t'(k1_reg);
                mb = m_t'(e_reg);
                st_next = S_A5;
            end
            S_A5: begin
                bias_next[ax_reg] = sat32(ext(bias_reg[ax_reg]) + qm);
                st_next = S_A6;
            end
            S_A6: begin
                ma = m_t'({1'b0, dt_reg});
                mb = m_t'(rmb);
                st_next = S_A7;
            end
            S_A7: begin
                integ_next[ax_reg] = sat32(ext(integ_reg[ax_reg]) + qm);
                if (ax_reg == 2'd2) begin
                    st_next = S_H0;
                end else begin
                    ax_next = ax_reg + 2'd1;
                    st_next = S_A0;
                end
            end
            // accel magnitude and height predict
            S_H0: begin
                ma = m_t'(in_reg[0]);
                mb = m_t'(in_reg[0]);
                st_next = S_H1;
            end
            S_H1: begin
                sq_next = prod_reg;
                ma = m_t'(in_reg[1]);
                mb = m_t'(in_reg[1]);
                st_next = S_H2;
            end
            S_H2: begin
                sq_next = sq_reg + prod_reg;
                ma = m_t'(in_reg[2]);
                mb = m_t'(in_reg[2]);
                st_next = S_H3;
            end
            S_H3: begin
                sq_next = sq_reg + prod_reg;
                st_next = S_H4;
            end
            S_H4: begin
                if (!launched_reg) begin
                    sq_start = 1'b1;
                    launched_next = 1'b1;
                end else if (sq_done) begin
                    launched_next = 1'b0;
                    accv_next = sat32(w_t'({31'd0, root}));
                    st_next = S_H5;
                end
            end
            S_H5: begin
                ma = m_t'({1'b0, dt_reg});
                mb = m_t'(hs_reg[1]);
                st_next = S_H6;
            end
            S_H6: begin
                acc_next = ext(hs_reg[0]) + qm;
                ma = m_t'({1'b0, dt_reg});
                mb = m_t'({1'b0, dt_reg});
                st_next = S_H7;
            end
            S_H7: begin
                tmp_next = qm >>> 1;
                st_next = S_H8;
            end
            S_H8: begin
                ma = m_t'(tmp_reg);
                mb = m_t'(accv_reg);
                st_next = S_H9;
            end
            S_H9: begin
                pred_next = sat32(acc_reg + qm);
                ma = m_t'({1'b0, dt_reg});
                mb = m_t'(accv_reg);
                st_next = S_H10;
            end
            S_H10: begin
                hs_next[1] = sat32(ext(hs_reg[1]) + qm);
                hsel_next = 1'b1;
                st_next = S_C0;
            end
            S_HU0: begin
                e_next = sat32(ext(in_reg[9]) - ext(pred_reg));
                st_next = S_HU1;
            end
            S_HU1: begin
                ma = m_t'(k0_reg);
                mb = m_t'(e_reg);
                st_next = S_HU2;
            end
            S_HU2: begin
                hs_next[0] = sat32(ext(pred_reg) + qm);
                ma = m_t'(k1_reg);
                mb = m_t'(e_reg);
                st_next = S_HU3;
            end
            S_HU3: begin
                hs_next[1] = sat32(ext(hs_reg[1]) + qm);
                st_next = S_OUT;
            end
            S_OUT: begin
                // hold here while the previous beat is still unread
                if (!ovalid_reg || m_tready) begin
                    out_next = {in_reg[9], hs_reg[0], integ_reg[2], integ_reg[1],
                                integ_reg[0], ang_reg[2], ang_reg[1], ang_reg[0]};
                    ovalid_next = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            launched_reg <= 1'b0;
            seeded_reg <= 1'b0;
            hsel_reg <= 1'b0;
            ax_reg <= 2'd0;
            dt_reg <= SAMPLE_PERIOD_RST;
            qv_reg <= VAR_RST;
            rv_reg <= VAR_RST;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                ang_reg[i] <= '0;
                bias_reg[i] <= '0;
                integ_reg[i] <= '0;
            end
            hs_reg[0] <= '0;
            hs_reg[1] <= '0;
            acov_reg[0] <= Q_ONE;
            acov_reg[1] <= '0;
            acov_reg[2] <= '0;
            acov_reg[3] <= Q_ONE;
            hcov_reg[0] <= Q_ONE;
            hcov_reg[1] <= '0;
            hcov_reg[2] <= '0;
            hcov_reg[3] <= Q_ONE;
        end else begin
            st_reg <= st_next;
            launched_reg <= launched_next;
            seeded_reg <= seeded_next;
            hsel_reg <= hsel_next;
            ax_reg <= ax_next;
            dt_reg <= dt_next;
            qv_reg <= qv_next;
            rv_reg <= rv_next;
            ovalid_reg <= ovalid_next;
            ang_reg <= ang_next;
            bias_reg <= bias_next;
            integ_reg <= integ_next;
            hs_reg <= hs_next;
            acov_reg <= acov_next;
            hcov_reg <= hcov_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        in_reg <= in_next;
        meas_reg <= meas_next;
        cr_reg <= cr_next;
        sr_reg <= sr_next;
        cp_reg <= cp_next;
        sp_reg <= sp_next;
        pred_reg <= pred_next;
        e_reg <= e_next;
        k0_reg <= k0_next;
        k1_reg <= k1_next;
        ca_reg <= ca_next;
        cb_reg <= cb_next;
        cc_reg <= cc_next;
        cd_reg <= cd_next;
        accv_reg <= accv_next;
        acc_reg <= acc_next;
        tmp_reg <= tmp_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
        prod_reg <= prod_next;
        s_reg <= s_next;
        sq_reg <= sq_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = out_reg;
endmodule
